// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the min tracking stack RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent falls in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// Shared types and constants for the min tracking stack.
// No dependencies.
package mts_pkg;

  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 64;
  localparam int COUNT_OUT_W   = 7;
  localparam int STATUS_W      = 2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// ===== rtl/mts_cell.sv =====
// One stack entry: loads from the entry above on push, from below on pop.
// Depends on mts_pkg.
module mts_cell #(
  parameter int W = mts_pkg::DATA_W
) (
  input  logic               clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  logic [W-1:0]       above_data,
  input  logic [W-1:0]       below_data,
  output logic [W-1:0]       data
);

  logic [W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= above_data;
    end else if (ctl.pop) begin
      data_r <= below_data;
    end
  end

  assign data = data_r;

endmodule

// ===== rtl/mts_chain.sv =====
// Row of mts_cell entries forming a shifting stack, top at cell 0.
// Depends on mts_pkg and mts_cell.
module mts_chain #(
  parameter int DEPTH = mts_pkg::DEFAULT_DEPTH,
  parameter int W     = mts_pkg::DATA_W
) (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  logic [W-1:0]        push_data,
  output logic [W-1:0]        top_data,
  output logic [W-1:0]        second_data
);

  logic [W-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] above;
    logic [W-1:0] below;
    if (i == 0) begin : g_first
      assign above = push_data;
    end else begin : g_mid_above
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_below
      assign below = cell_q[i+1];
    end
    mts_cell #(.W(W)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .above_data (above),
      .below_data (below),
      .data       (cell_q[i])
    );
  end

  assign top_data    = cell_q[0];
  assign second_data = cell_q[1];

endmodule

// ===== rtl/min_tracking_stack_core.sv =====
// Min tracking stack: value stack and minimum stack as shifting cell rows.
// Results are registered on the input transfer. Throughput: 1 item per
// cycle while out_ready is high; each cell row shifts one entry per cycle.
// Reset clears entry and minimum counts and the output valid; cell
// contents are undefined until pushed. Depends on mts_pkg, mts_chain.
`include "assert_macros.svh"

module min_tracking_stack_core #(
  parameter int STACK_DEPTH = mts_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic signed [mts_pkg::DATA_W-1:0]    in_push_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mts_pkg::STATUS_W-1:0]         out_status,
  output logic signed [mts_pkg::DATA_W-1:0]    out_popped_value,
  output logic                                 out_popped_valid,
  output logic signed [mts_pkg::DATA_W-1:0]    out_current_min,
  output logic                                 out_min_valid,
  output logic [mts_pkg::COUNT_OUT_W-1:0]      out_stack_count
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int W     = mts_pkg::DATA_W;

  logic [CNT_W-1:0] entry_cnt_r, entry_cnt_nxt;
  logic [CNT_W-1:0] min_cnt_r, min_cnt_nxt;

  logic                         out_valid_r;
  logic [mts_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [W-1:0]                 popped_r, popped_nxt;
  logic                         popped_ok_r, popped_ok_nxt;
  logic [W-1:0]                 min_r, min_nxt;
  logic                         min_ok_r, min_ok_nxt;
  logic [CNT_W-1:0]             count_r;

  logic [W-1:0] val_top, val_second, min_top, min_second;
  logic         accept, is_push, push_ok, pop_ok, min_push, min_pop;
  mts_pkg::shift_ctl_t val_ctl, min_ctl;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_push  = (in_req_type == mts_pkg::REQ_PUSH);
  assign push_ok  = is_push && (entry_cnt_r != CNT_W'(STACK_DEPTH));
  assign pop_ok   = !is_push && (entry_cnt_r != '0);
  assign min_push = push_ok && (min_cnt_r != CNT_W'(STACK_DEPTH)) &&
                    ((min_cnt_r == '0) || ($signed(in_push_value) <= $signed(min_top)));
  assign min_pop  = pop_ok && (min_cnt_r != '0) && (min_top == val_top);

  always_comb begin
    val_ctl.push = accept && push_ok;
    val_ctl.pop  = accept && pop_ok;
    min_ctl.push = accept && min_push;
    min_ctl.pop  = accept && min_pop;
  end

  mts_chain #(.DEPTH(STACK_DEPTH), .W(W)) u_val_chain (
    .clk         (clk),
    .ctl         (val_ctl),
    .push_data   (in_push_value),
    .top_data    (val_top),
    .second_data (val_second)
  );

  mts_chain #(.DEPTH(STACK_DEPTH), .W(W)) u_min_chain (
    .clk         (clk),
    .ctl         (min_ctl),
    .push_data   (in_push_value),
    .top_data    (min_top),
    .second_data (min_second)
  );

  always_comb begin
    entry_cnt_nxt = entry_cnt_r;
    min_cnt_nxt   = min_cnt_r;
    status_nxt    = mts_pkg::ST_OK;
    popped_nxt    = '0;
    popped_ok_nxt = 1'b0;
    if (is_push) begin
      if (push_ok) begin
        entry_cnt_nxt = entry_cnt_r + CNT_W'(1);
      end else begin
        status_nxt = mts_pkg::ST_PUSH_FULL;
      end
    end else begin
      if (pop_ok) begin
        entry_cnt_nxt = entry_cnt_r - CNT_W'(1);
        popped_nxt    = val_top;
        popped_ok_nxt = 1'b1;
      end else begin
        status_nxt = mts_pkg::ST_POP_EMPTY;
      end
    end
    if (min_push) begin
      min_cnt_nxt = min_cnt_r + CNT_W'(1);
    end else if (min_pop) begin
      min_cnt_nxt = min_cnt_r - CNT_W'(1);
    end
    min_ok_nxt = (entry_cnt_nxt != '0) && (min_cnt_nxt != '0);
    if (!min_ok_nxt) begin
      min_nxt = '0;
    end else if (min_push) begin
      min_nxt = in_push_value;
    end else if (min_pop) begin
      min_nxt = min_second;
    end else begin
      min_nxt = min_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt_r <= '0;
      min_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        entry_cnt_r <= entry_cnt_nxt;
        min_cnt_r   <= min_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      popped_r    <= popped_nxt;
      popped_ok_r <= popped_ok_nxt;
      min_r       <= min_nxt;
      min_ok_r    <= min_ok_nxt;
      count_r     <= entry_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_popped_valid = popped_ok_r;
  assign out_current_min  = min_r;
  assign out_min_valid    = min_ok_r;
  assign out_stack_count  = mts_pkg::COUNT_OUT_W'({{mts_pkg::COUNT_OUT_W{1'b0}}, count_r});

  `MTS_ASSERT(a_min_le_entry, min_cnt_r <= entry_cnt_r, "min count exceeds entry count")
  `MTS_ASSERT(a_nonempty_has_min, (entry_cnt_r == '0) || (min_cnt_r != '0), "stack holds entries but no minimum")
  `MTS_ASSERT(a_count_bound, entry_cnt_r <= CNT_W'(STACK_DEPTH), "entry count beyond depth")
  `MTS_ASSERT_NEXT(a_empty_pop, accept && !is_push && (entry_cnt_r == '0), (out_status == mts_pkg::ST_POP_EMPTY) && !out_popped_valid, "pop on empty stack not reported")

endmodule
